// ===== src/assert_macros.svh =====
// Assertion macros used by the port-level checker (m4ci_checker).
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_SAME(lbl, ck, rn, a, c) \
lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
else $error("check failed");

// next-cycle implication
`define CHK_NEXT(lbl, ck, rn, a, c) \
lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
else $error("check failed");

`endif

// ===== src/m4ci_pkg.sv =====
// Shared widths, command types and sequencing functions of the 4x4 inverse unit.
// No dependencies.
`timescale 1ns / 1ps
package m4ci_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int EW = 32;   // element
	localparam int MW = 64;   // 2x2 minor, wraps
	localparam int CW = 97;   // cofactor, signed
	localparam int AW = 132;  // accumulator
	localparam int BW = 34;   // multiplier b operand
	localparam int PW = 66;   // product
	localparam int DW = 129;  // determinant magnitude
	localparam int QW = 32;   // quotient

	typedef enum logic [2:0] {OP_NOP, OP_MAC, OP_ST_MIN, OP_ST_COF, OP_ST_DET} op_t;
	typedef enum logic [1:0] {BS_MAT, BS_MIN, BS_COF} bsel_t;

	typedef struct packed {
		op_t        op;
		logic       clr;
		logic       neg;
		bsel_t      bsel;
		logic [1:0] sh;
		logic [3:0] a_addr;
		logic [3:0] b_addr;
		logic [3:0] idx;
		logic       div_start;
		logic [3:0] out_idx;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} stat_t;

	function automatic logic [1:0] other_idx(input logic [1:0] x, input logic [1:0] k);
		return (k < x) ? k : k + 2'd1;
	endfunction

	function automatic cmd_t cmd_nop();
		cmd_t m;
		m = '0;
		m.op = OP_NOP;
		m.bsel = BS_MAT;
		return m;
	endfunction

	// cofactor n = {row, col}: three minors, then the three-term expansion
	function automatic cmd_t cof_cmd(input logic [3:0] n, input logic [3:0] step);
		logic [1:0] r0, r1, r2, c0, c1, c2;
		logic s;
		cmd_t m;
		r0 = other_idx(n[3:2], 2'd0);
		r1 = other_idx(n[3:2], 2'd1);
		r2 = other_idx(n[3:2], 2'd2);
		c0 = other_idx(n[1:0], 2'd0);
		c1 = other_idx(n[1:0], 2'd1);
		c2 = other_idx(n[1:0], 2'd2);
		s = n[2] ^ n[0];
		m = cmd_nop();
		m.op = OP_MAC;
		case (step)
			4'd0: begin
				m.clr = 1'b1; m.a_addr = {r1, c1}; m.b_addr = {r2, c2};
			end
			4'd1: begin
				m.neg = 1'b1; m.a_addr = {r1, c2}; m.b_addr = {r2, c1};
			end
			4'd2: begin
				m.op = OP_ST_MIN; m.idx = 4'd0;
			end
			4'd3: begin
				m.clr = 1'b1; m.a_addr = {r1, c0}; m.b_addr = {r2, c2};
			end
			4'd4: begin
				m.neg = 1'b1; m.a_addr = {r1, c2}; m.b_addr = {r2, c0};
			end
			4'd5: begin
				m.op = OP_ST_MIN; m.idx = 4'd1;
			end
			4'd6: begin
				m.clr = 1'b1; m.a_addr = {r1, c0}; m.b_addr = {r2, c1};
			end
			4'd7: begin
				m.neg = 1'b1; m.a_addr = {r1, c1}; m.b_addr = {r2, c0};
			end
			4'd8: begin
				m.op = OP_ST_MIN; m.idx = 4'd2;
			end
			4'd9, 4'd10: begin
				m.clr = (step == 4'd9); m.neg = s; m.a_addr = {r0, c0};
				m.bsel = BS_MIN; m.b_addr = 4'd0; m.sh = {1'b0, step[0] ^ 1'b1};
			end
			4'd11, 4'd12: begin
				m.neg = ~s; m.a_addr = {r0, c1};
				m.bsel = BS_MIN; m.b_addr = 4'd1; m.sh = {1'b0, step[0]};
			end
			4'd13, 4'd14: begin
				m.neg = s; m.a_addr = {r0, c2};
				m.bsel = BS_MIN; m.b_addr = 4'd2; m.sh = {1'b0, step[0] ^ 1'b1};
			end
			default: begin
				m.op = OP_ST_COF; m.idx = n;
			end
		endcase
		return m;
	endfunction

	// determinant term k, limb l of cofactor (0,k)
	function automatic cmd_t det_cmd(input logic [1:0] k, input logic [1:0] l);
		cmd_t m;
		m = cmd_nop();
		m.op = OP_MAC;
		m.clr = (k == 2'd0) && (l == 2'd0);
		m.a_addr = {2'd0, k};
		m.bsel = BS_COF;
		m.b_addr = {2'd0, k};
		m.sh = l;
		return m;
	endfunction

	function automatic cmd_t det_store_cmd();
		cmd_t m;
		m = cmd_nop();
		m.op = OP_ST_DET;
		return m;
	endfunction

	function automatic cmd_t div_cmd(input logic [3:0] o);
		cmd_t m;
		m = cmd_nop();
		m.div_start = 1'b1;
		m.out_idx = o;
		return m;
	endfunction

endpackage

// ===== src/m4ci_ctrl.sv =====
// Sequencer of the 4x4 inverse unit: issues MAC/store ops and division beats.
// Depends on m4ci_pkg.
`timescale 1ns / 1ps
module m4ci_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            compute_now,
	output logic            busy,
	output m4ci_pkg::cmd_t  cmd,
	input  m4ci_pkg::stat_t stat
);
	import m4ci_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_COF, S_DET, S_DST, S_WAIT, S_DIV, S_DWAIT} state_t;

	state_t     state_q;
	logic       busy_q;
	cmd_t       cmd_q;
	logic [3:0] n_q, step_q, o_q;
	logic [1:0] k_q, l_q, wcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			cmd_q   <= cmd_nop();
			n_q     <= '0;
			step_q  <= '0;
			o_q     <= '0;
			k_q     <= '0;
			l_q     <= '0;
			wcnt_q  <= '0;
		end else begin
			cmd_q <= cmd_nop();
			case (state_q)
				S_IDLE: begin
					if (start && compute_now) begin
						state_q <= S_COF;
						busy_q  <= 1'b1;
						n_q     <= '0;
						step_q  <= '0;
					end
				end
				S_COF: begin
					cmd_q  <= cof_cmd(n_q, step_q);
					step_q <= step_q + 4'd1;
					if (step_q == 4'd15) begin
						n_q <= n_q + 4'd1;
						if (n_q == 4'd15) begin
							state_q <= S_DET;
							k_q     <= '0;
							l_q     <= '0;
						end
					end
				end
				S_DET: begin
					cmd_q <= det_cmd(k_q, l_q);
					if (l_q == 2'd2) begin
						l_q <= '0;
						k_q <= k_q + 2'd1;
						if (k_q == 2'd3) state_q <= S_DST;
					end else begin
						l_q <= l_q + 2'd1;
					end
				end
				S_DST: begin
					cmd_q   <= det_store_cmd();
					state_q <= S_WAIT;
					wcnt_q  <= 2'd3;
				end
				S_WAIT: begin
					if (wcnt_q == 2'd0) begin
						state_q <= S_DIV;
						o_q     <= '0;
					end else begin
						wcnt_q <= wcnt_q - 2'd1;
					end
				end
				S_DIV: begin
					cmd_q   <= div_cmd(o_q);
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (stat.div_done) begin
						if (o_q == 4'd15) begin
							state_q <= S_IDLE;
							busy_q  <= 1'b0;
						end else begin
							o_q     <= o_q + 4'd1;
							state_q <= S_DIV;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = busy_q;
	assign cmd  = cmd_q;

endmodule

// ===== src/m4ci_divider.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit quotient with overflow flag.
// Depends on m4ci_pkg.
`timescale 1ns / 1ps
module m4ci_divider #(
	parameter int NW = 128
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [NW-1:0]           num,
	input  logic [m4ci_pkg::DW-1:0] den,
	output logic                    done,
	output logic [m4ci_pkg::QW-1:0] quo,
	output logic                    ovf
);
	import m4ci_pkg::*;

	localparam int NH = NW - QW;
	localparam int CNTW = $clog2(QW);

	logic            run_q, done_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW:0]     rem_q, trial, num_hi;
	logic [QW-1:0]   low_q, quo_q;
	logic            ovf_q, ge;

	assign num_hi = {{(DW + 1 - NH){1'b0}}, num[NW-1:QW]};
	assign trial  = {rem_q[DW-1:0], low_q[QW-1]};
	assign ge     = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(QW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num_hi;
			low_q <= num[QW-1:0];
			ovf_q <= num_hi >= {1'b0, den};
		end else if (run_q) begin
			rem_q <= ge ? (trial - {1'b0, den}) : trial;
			low_q <= {low_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign ovf  = ovf_q;

endmodule

// ===== src/m4ci_datapath.sv =====
// Datapath: element memory, shared 32x34 MAC, minor/cofactor/determinant registers,
// divider and result register. Depends on m4ci_pkg and m4ci_divider.
`timescale 1ns / 1ps
module m4ci_datapath #(
	parameter int FRAC_BITS = m4ci_pkg::FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic [3:0]              wr_addr,
	input  logic signed [31:0]      wr_data,
	input  m4ci_pkg::cmd_t          cmd,
	output m4ci_pkg::stat_t         stat,
	output logic                    result_valid,
	output logic [1:0]              out_row,
	output logic [1:0]              out_col,
	output logic signed [31:0]      out_value,
	output logic                    singular,
	output logic                    clipped,
	output logic                    last
);
	import m4ci_pkg::*;

	localparam int NW = CW - 1 + 2 * FRAC_BITS;
	localparam logic [EW-1:0] ONE_VAL = EW'(1) << FRAC_BITS;

	logic [EW-1:0] mem [16];
	logic [15:0]   vld_q;

	logic [MW-1:0] min_q [3];
	logic [CW-1:0] cof_q [16];
	logic [AW-1:0] acc_q;
	logic [DW-1:0] dmag_q;
	logic          dneg_q, sing_q;

	cmd_t ctrl_s1, ctrl_s2;
	logic signed [EW-1:0] rd_a_s1, rd_b_s1;
	logic signed [BW-1:0] limb_s1, limb, b_op;
	logic signed [PW-1:0] prod_s2;

	logic [MW-1:0] mn;
	logic [CW-1:0] cf;
	logic [AW-1:0] term_ext, term, base, sum, det_abs;

	logic [CW-1:0] cnum, cabs;
	logic [NW-1:0] nmag_q;
	logic          cneg_q, divgo_q;
	logic [3:0]    oidx_q;

	logic          dv_done, dv_ovf, neg, clip;
	logic [QW-1:0] dv_quo, limit, mag;

	logic          res_v_q, sing_o_q, clip_o_q, last_o_q;
	logic [1:0]    row_o_q, col_o_q;
	logic [QW-1:0] val_o_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (wr_en) vld_q[wr_addr] <= 1'b1;
	end

	// operand fetch
	always_comb begin
		mn = min_q[cmd.b_addr[1:0]];
		cf = cof_q[cmd.b_addr];
		case (cmd.bsel)
			BS_MIN: limb = cmd.sh[0] ? {{2{mn[63]}}, mn[63:32]} : {2'b00, mn[31:0]};
			BS_COF: begin
				case (cmd.sh)
					2'd0:    limb = {2'b00, cf[31:0]};
					2'd1:    limb = {2'b00, cf[63:32]};
					default: limb = {cf[CW-1], cf[CW-1:64]};
				endcase
			end
			default: limb = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		rd_a_s1 <= vld_q[cmd.a_addr] ? mem[cmd.a_addr]
			: ((cmd.a_addr[3:2] == cmd.a_addr[1:0]) ? ONE_VAL : '0);
		rd_b_s1 <= vld_q[cmd.b_addr] ? mem[cmd.b_addr]
			: ((cmd.b_addr[3:2] == cmd.b_addr[1:0]) ? ONE_VAL : '0);
		limb_s1 <= limb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= cmd_nop();
			ctrl_s2 <= cmd_nop();
			divgo_q <= 1'b0;
		end else begin
			ctrl_s1 <= cmd;
			ctrl_s2 <= ctrl_s1;
			divgo_q <= cmd.div_start;
		end
	end

	// multiply
	assign b_op = (ctrl_s1.bsel == BS_MAT) ? {{2{rd_b_s1[EW-1]}}, rd_b_s1} : limb_s1;

	always_ff @(posedge clk) begin
		prod_s2 <= rd_a_s1 * b_op;
	end

	// accumulate and store
	assign term_ext = {{(AW - PW){prod_s2[PW-1]}}, prod_s2};

	always_comb begin
		case (ctrl_s2.sh)
			2'd0:    term = term_ext;
			2'd1:    term = term_ext << 32;
			default: term = term_ext << 64;
		endcase
	end

	assign base    = ctrl_s2.clr ? '0 : acc_q;
	assign sum     = ctrl_s2.neg ? (base - term) : (base + term);
	assign det_abs = acc_q[AW-1] ? (AW'(0) - acc_q) : acc_q;

	always_ff @(posedge clk) begin
		case (ctrl_s2.op)
			OP_MAC:    acc_q <= sum;
			OP_ST_MIN: min_q[ctrl_s2.idx[1:0]] <= acc_q[MW-1:0];
			OP_ST_COF: cof_q[ctrl_s2.idx] <= acc_q[CW-1:0];
			OP_ST_DET: begin
				sing_q <= (acc_q == '0);
				dneg_q <= acc_q[AW-1];
				dmag_q <= (acc_q == '0) ? DW'(1) : det_abs[DW-1:0];
			end
			default: ;
		endcase
	end

	// numerator for output (i,j) is cofactor (j,i)
	assign cnum = cof_q[{cmd.out_idx[1:0], cmd.out_idx[3:2]}];
	assign cabs = cnum[CW-1] ? (CW'(0) - cnum) : cnum;

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			nmag_q <= {cabs[CW-2:0], {(2 * FRAC_BITS){1'b0}}};
			cneg_q <= cnum[CW-1];
			oidx_q <= cmd.out_idx;
		end
	end

	m4ci_divider #(.NW(NW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (divgo_q),
		.num    (nmag_q),
		.den    (dmag_q),
		.done   (dv_done),
		.quo    (dv_quo),
		.ovf    (dv_ovf)
	);

	assign neg   = cneg_q ^ dneg_q;
	assign limit = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
	assign clip  = dv_ovf || (dv_quo > limit);
	assign mag   = clip ? limit : dv_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_v_q <= 1'b0;
		else res_v_q <= dv_done;
	end

	always_ff @(posedge clk) begin
		if (dv_done) begin
			row_o_q  <= oidx_q[3:2];
			col_o_q  <= oidx_q[1:0];
			val_o_q  <= neg ? (QW'(0) - mag) : mag;
			sing_o_q <= sing_q;
			clip_o_q <= clip;
			last_o_q <= (oidx_q == 4'd15);
		end
	end

	assign stat.div_done = dv_done;
	assign result_valid  = res_v_q;
	assign out_row       = row_o_q;
	assign out_col       = col_o_q;
	assign out_value     = val_o_q;
	assign singular      = sing_o_q;
	assign clipped       = clip_o_q;
	assign last          = last_o_q & res_v_q;

endmodule

// ===== src/matrix4x4_cofactor_inverse_unit.sv =====
// 4x4 fixed-point inverse by cofactors. An item is taken when start is high and busy
// is low; it writes one element (the matrix resets to identity), so plain writes may
// come every cycle. With compute_now set, busy rises and the unit runs the cofactor
// ops and then the determinant on one 32x34 multiplier (one product per cycle), then
// sixteen results follow one after another, each set by the bit-serial divider
// (32 quotient bits, one per cycle). Each result stands one cycle with result_valid;
// last marks row 3, column 3. Results cannot be stalled.
// Depends on m4ci_pkg, m4ci_ctrl, m4ci_datapath.
`timescale 1ns / 1ps
module matrix4x4_cofactor_inverse_unit #(
	parameter int FRAC_BITS = m4ci_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         elem_row,
	input  logic [1:0]         elem_col,
	input  logic signed [31:0] elem_value,
	input  logic               compute_now,
	output logic               result_valid,
	output logic [1:0]         out_row,
	output logic [1:0]         out_col,
	output logic signed [31:0] out_value,
	output logic               singular,
	output logic               clipped,
	output logic               last
);
	import m4ci_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  wr_en;

	assign wr_en = start & ~busy;

	m4ci_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (wr_en),
		.compute_now (compute_now),
		.busy        (busy),
		.cmd         (cmd),
		.stat        (stat)
	);

	m4ci_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_addr      ({elem_row, elem_col}),
		.wr_data      (elem_value),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.out_row      (out_row),
		.out_col      (out_col),
		.out_value    (out_value),
		.singular     (singular),
		.clipped      (clipped),
		.last         (last)
	);

endmodule

// ===== src/m4ci_checker.sv =====
// Port-level checks of the 4x4 inverse unit, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module m4ci_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       compute_now,
	input logic       result_valid,
	input logic       last,
	input logic [1:0] out_row,
	input logic [1:0] out_col
);
	`CHK_NEXT(a_compute_busy, clk, arst_n, start && !busy && compute_now, busy)
	`CHK_SAME(a_beat_in_run, clk, arst_n, result_valid && !last, busy)
	`CHK_NEXT(a_beat_spacing, clk, arst_n, result_valid, !result_valid)
	`CHK_SAME(a_last_pos, clk, arst_n, last, result_valid && out_row == 2'd3 && out_col == 2'd3)
endmodule

bind matrix4x4_cofactor_inverse_unit m4ci_checker u_chk (.*);

// ===== bench/m4ci_inverse_checker.sv =====
// Checker for the 4x4 cofactor inverse unit: mirrors the element store, predicts the
// sixteen inverse beats of each compute and compares them with the result port.
// Depends on the port list of matrix4x4_cofactor_inverse_unit only.
`timescale 1ns / 1ps
module m4ci_inverse_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         elem_row,
	input  logic [1:0]         elem_col,
	input  logic signed [31:0] elem_value,
	input  logic               compute_now,
	input  logic               result_valid,
	input  logic [1:0]         out_row,
	input  logic [1:0]         out_col,
	input  logic signed [31:0] out_value,
	input  logic               singular,
	input  logic               clipped,
	input  logic               last,
	output int                 fail_count,
	output int                 pending,
	output int                 inversions,
	output int                 singular_runs,
	output int                 clipped_beats
);
	localparam int FRAC = 16;

	typedef struct packed {
		logic [1:0]  row;
		logic [1:0]  col;
		logic [31:0] value;
		logic        sing;
		logic        clip;
		logic        last;
	} inv_beat_t;

	logic signed [31:0] elems [16];
	inv_beat_t inverse_q[$];

	function automatic logic signed [31:0] el(int r, int c);
		return elems[r * 4 + c];
	endfunction

	function automatic logic signed [191:0] cofactor_of(int r, int c);
		int rs[3], cs[3];
		int n, k;
		logic signed [63:0] m0, m1, m2;
		logic signed [191:0] w0, w1, w2, d;
		n = 0;
		for (k = 0; k < 4; k++) if (k != r) begin rs[n] = k; n++; end
		n = 0;
		for (k = 0; k < 4; k++) if (k != c) begin cs[n] = k; n++; end
		// 2x2 minors wrap at 64 bits
		m0 = el(rs[1], cs[1]) * el(rs[2], cs[2]) - el(rs[1], cs[2]) * el(rs[2], cs[1]);
		m1 = el(rs[1], cs[0]) * el(rs[2], cs[2]) - el(rs[1], cs[2]) * el(rs[2], cs[0]);
		m2 = el(rs[1], cs[0]) * el(rs[2], cs[1]) - el(rs[1], cs[1]) * el(rs[2], cs[0]);
		w0 = m0;
		w1 = m1;
		w2 = m2;
		d = w0 * el(rs[0], cs[0]) - w1 * el(rs[0], cs[1]) + w2 * el(rs[0], cs[2]);
		if (((r + c) & 1) != 0) d = -d;
		return d;
	endfunction

	function automatic void predict_inverse();
		logic signed [191:0] cof [16];
		logic signed [191:0] det;
		logic [191:0] dmag, nmag, q;
		logic sing, dneg, neg, clip;
		logic [31:0] lim, mag;
		inv_beat_t b;
		int i, j, k;
		for (i = 0; i < 16; i++) cof[i] = cofactor_of(i / 4, i % 4);
		det = '0;
		for (k = 0; k < 4; k++) det = det + cof[k] * el(0, k);
		sing = (det == 0);
		if (sing) det = 1;
		dneg = det[191];
		dmag = dneg ? -det : det;
		if (sing) singular_runs++;
		for (i = 0; i < 4; i++)
			for (j = 0; j < 4; j++) begin
				nmag = cof[j * 4 + i][191] ? -cof[j * 4 + i] : cof[j * 4 + i];
				neg = cof[j * 4 + i][191] != dneg;
				nmag = nmag << (2 * FRAC);
				q = nmag / dmag;
				lim = neg ? 32'h8000_0000 : 32'h7fff_ffff;
				clip = (q[191:32] != 0) || (q[31:0] > lim);
				mag = clip ? lim : q[31:0];
				b.row = i[1:0];
				b.col = j[1:0];
				b.value = neg ? -mag : mag;
				b.sing = sing;
				b.clip = clip;
				b.last = (i == 3) && (j == 3);
				inverse_q.push_back(b);
			end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		inv_beat_t e;
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) elems[i] = (i % 5 == 0) ? (32'sd1 <<< FRAC) : 32'sd0;
			fail_count = 0;
			inversions = 0;
			singular_runs = 0;
			clipped_beats = 0;
			inverse_q.delete();
			pending = 0;
		end else begin
			if (result_valid) begin
				if (inverse_q.size() == 0) begin
					$display("%0t: unexpected result beat r%0d c%0d value %h", $time,
						out_row, out_col, out_value);
					fail_count++;
				end else begin
					e = inverse_q.pop_front();
					if (clipped) clipped_beats++;
					if ({out_row, out_col, out_value, singular, clipped, last} !== e) begin
						$display("%0t: mismatch exp r%0d c%0d v=%h s%0d c%0d l%0d", $time,
							e.row, e.col, e.value, e.sing, e.clip, e.last);
						$display("%0t:          act r%0d c%0d v=%h s%0d c%0d l%0d", $time,
							out_row, out_col, out_value, singular, clipped, last);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				elems[elem_row * 4 + elem_col] = elem_value;
				if (compute_now) begin
					inversions++;
					predict_inverse();
				end
			end
			pending = inverse_q.size();
		end
	end
endmodule

// ===== bench/tb.sv =====
// Top of the 4x4 cofactor inverse bench: clock, reset, element writes and verdict.
// Depends on matrix4x4_cofactor_inverse_unit and m4ci_inverse_checker.
`timescale 1ns / 1ps
module tb;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] elem_row = '0;
	logic [1:0] elem_col = '0;
	logic signed [31:0] elem_value = '0;
	logic compute_now = 1'b0;
	logic result_valid;
	logic [1:0] out_row, out_col;
	logic signed [31:0] out_value;
	logic singular, clipped, last;
	int fail_count, pending, inversions, singular_runs, clipped_beats;
	int items = 0;
	int idle_cycles = 0;
	localparam int WATCHDOG = 20000;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	matrix4x4_cofactor_inverse_unit dut (.*);

	m4ci_inverse_checker chk (.*);

	always @(posedge clk) begin
		if ((start && !busy) || result_valid) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic write_elem(int r, int c, logic [31:0] v, logic go);
		while (busy) @(negedge clk);
		start = 1'b1;
		elem_row = r[1:0];
		elem_col = c[1:0];
		elem_value = v;
		compute_now = go;
		@(negedge clk);
		items++;
	endtask

	task automatic idle_gap();
		int g;
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) g = 0;
		else if (p < 92) g = $urandom_range(1, 4);
		else g = $urandom_range(20, 150);
		if (g > 0) begin
			start = 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	function automatic logic [31:0] rand_elem();
		int p;
		p = $urandom_range(0, 9);
		if (p == 0) return $urandom();
		if (p == 1) return 32'd0;
		return $urandom_range(0, 1 << 19) - (1 << 18);
	endfunction

	initial begin
		int n;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// identity, singular, tiny pivots that saturate, extreme values
		write_elem(0, 0, 32'h0001_0000, 1'b1);
		write_elem(0, 0, 32'h0000_0000, 1'b1);
		write_elem(0, 0, 32'h0000_0001, 1'b1);
		write_elem(0, 0, 32'hffff_ffff, 1'b1);
		write_elem(0, 0, 32'h8000_0000, 1'b1);
		write_elem(0, 0, 32'h7fff_ffff, 1'b1);
		write_elem(3, 3, 32'h8000_0000, 1'b0);
		write_elem(1, 2, 32'h7fff_ffff, 1'b0);
		write_elem(2, 1, 32'h8000_0000, 1'b1);
		for (int i = 0; i < 16; i++)
			write_elem(i / 4, i % 4, (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff, i == 15);
		idle_gap();
		// random: mostly full matrix loads then compute, some stray writes and computes
		while (items < 420) begin
			if ($urandom_range(0, 3) != 0) begin
				n = $urandom_range(0, 15);
				for (int i = 0; i < 16; i++) begin
					write_elem((n + i) % 16 / 4, (n + i) % 4, rand_elem(), i == 15);
					idle_gap();
				end
			end else begin
				write_elem($urandom_range(0, 3), $urandom_range(0, 3), rand_elem(),
					$urandom_range(0, 5) == 0);
				idle_gap();
			end
		end
		start = 1'b0;
		compute_now = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		$display("Wrote %0d elements, checked %0d inversions (%0d singular).",
			items, inversions, singular_runs);
		$display("%0d result beats saturated.", clipped_beats);
		if (fail_count == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+src
src/m4ci_pkg.sv
src/m4ci_ctrl.sv
src/m4ci_divider.sv
src/m4ci_datapath.sv
src/matrix4x4_cofactor_inverse_unit.sv
src/m4ci_checker.sv
bench/m4ci_inverse_checker.sv
bench/tb.sv
